@@ src/rmis_pkg.sv @@
package rmis_pkg;

	// run mode codes (code 7 is unused and steps like forward)
	localparam logic [2:0] RUN_FORWARD    = 3'd0;
	localparam logic [2:0] RUN_REVERSE    = 3'd1;
	localparam logic [2:0] RUN_PINGPONG   = 3'd2;
	localparam logic [2:0] RUN_PENDULUM   = 3'd3;
	localparam logic [2:0] RUN_BROWNIAN   = 3'd4;
	localparam logic [2:0] RUN_RANDOM     = 3'd5;
	localparam logic [2:0] RUN_EXT_RANDOM = 3'd6;

	// func codes
	localparam logic FUNC_INIT = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// history bases, one per mode family
	localparam logic [15:0] BASE_FWD = 16'h1000;
	localparam logic [15:0] BASE_REV = 16'h2000;
	localparam logic [15:0] BASE_PPG = 16'h3000;
	localparam logic [15:0] BASE_PEN = 16'h4000;
	localparam logic [15:0] BASE_BRN = 16'h5000;
	localparam logic [15:0] BASE_RND = 16'h6000;
	localparam logic [15:0] HIST_SPAN = 16'h0FFF;
	localparam logic [11:0] CNT_SAT   = 12'hFFF;

	// random word width and modulo divisor width
	localparam int RND_W = 32;
	localparam int DIV_W = 7;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture word fields, start modulo
		logic commit;  // update position and history
	} rmis_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_done;
	} rmis_sts_t;

endpackage

@@ src/rmis_mod.sv @@
module rmis_mod
	import rmis_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [DIV_W-2:0] rem,
	output logic             done
);

	localparam int CNT_W = $clog2(RND_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [RND_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-2:0] rem_q;
	logic [DIV_W-1:0] trial;

	// shift in one dividend bit per cycle, remainder stays below divisor
	assign trial = {rem_q, dvd_q[RND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(RND_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// restoring remainder datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			if (trial >= dsr_q) begin
				rem_q <= (DIV_W-1)'(trial - dsr_q);
			end else begin
				rem_q <= trial[DIV_W-2:0];
			end
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

@@ src/rmis_ctrl.sv @@
module rmis_ctrl
	import rmis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	output logic      res_valid,
	input  logic      res_stall,
	output rmis_cmd_t cmd,
	input  rmis_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   out_free;

	assign out_free   = !res_valid_q || !res_stall;
	assign cmd_stall  = (state_q != ST_IDLE);
	assign res_valid  = res_valid_q;
	assign cmd.load   = (state_q == ST_IDLE) && cmd_valid;
	assign cmd.commit = (state_q == ST_FIN) && out_free;

	// sequencer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.mod_done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ src/rmis_dp.sv @@
module rmis_dp
	import rmis_pkg::*;
#(
	parameter int INDEX_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rmis_cmd_t        cmd,
	output rmis_sts_t        sts,
	input  logic             func,
	input  logic [2:0]       run_mode,
	input  logic [5:0]       start_index,
	input  logic [5:0]       end_index,
	input  logic [6:0]       repeats,
	input  logic [RND_W-1:0] random_word,
	output logic [5:0]       position,
	output logic             span_done
);

	localparam logic [8:0] IDX_LIM = 9'(INDEX_COUNT - 1);

	logic [5:0]       st_c, en_r, en_c;
	logic [6:0]       span_c;
	logic [DIV_W-1:0] divisor;
	logic [DIV_W-2:0] rem;
	logic             mod_done;

	logic       func_q;
	logic [2:0] mode_q;
	logic [5:0] st_q, en_q;
	logic [6:0] span_q, reps_q;

	logic [5:0]  pos_q;
	logic [15:0] hist_q;
	logic        done_q;

	logic [5:0]  pos_n;
	logic [15:0] hist_n;
	logic        done_n;

	// clamp range to the index count, raise end to start
	always_comb begin
		st_c   = ({3'b0, start_index} > IDX_LIM) ? IDX_LIM[5:0] : start_index;
		en_r   = ({3'b0, end_index} > IDX_LIM) ? IDX_LIM[5:0] : end_index;
		en_c   = (en_r < st_c) ? st_c : en_r;
		span_c = 7'({1'b0, en_c} - {1'b0, st_c} + 7'd1);
	end

	assign divisor = (run_mode == RUN_BROWNIAN) ? DIV_W'(3) : span_c;

	rmis_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (random_word),
		.divisor  (divisor),
		.rem      (rem),
		.done     (mod_done)
	);

	assign sts.mod_done = mod_done;

	// word fields held while the modulo runs
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			mode_q <= run_mode;
			st_q   <= st_c;
			en_q   <= en_c;
			span_q <= span_c;
			reps_q <= repeats;
		end
	end

	// next position and history
	always_comb begin
		logic [15:0] base;
		logic [15:0] reload;
		logic [15:0] h1;
		logic [13:0] cnt_full;
		logic [11:0] cnt_sat;
		logic [6:0]  i7, st7, en7, t7;

		i7       = {1'b0, pos_q};
		st7      = {1'b0, st_q};
		en7      = {1'b0, en_q};
		t7       = i7 + 7'(rem);
		cnt_full = span_q * reps_q;
		cnt_sat  = (cnt_full > 14'(CNT_SAT)) ? CNT_SAT : cnt_full[11:0];

		case (mode_q) inside
			RUN_REVERSE: begin
				base   = BASE_REV;
				reload = BASE_REV + 16'(reps_q);
			end
			RUN_PINGPONG: begin
				base   = BASE_PPG;
				reload = BASE_PPG + 16'({reps_q, 1'b0});
			end
			RUN_PENDULUM: begin
				base   = BASE_PEN;
				reload = BASE_PEN + 16'({reps_q, 1'b0});
			end
			RUN_BROWNIAN: begin
				base   = BASE_BRN;
				reload = BASE_BRN + 16'(cnt_sat);
			end
			RUN_RANDOM, RUN_EXT_RANDOM: begin
				base   = BASE_RND;
				reload = BASE_RND + 16'(cnt_sat);
			end
			default: begin
				base   = BASE_FWD;
				reload = BASE_FWD + 16'(reps_q);
			end
		endcase

		h1 = ((hist_q <= base) || (hist_q > base + HIST_SPAN)) ? reload : hist_q;

		pos_n  = pos_q;
		hist_n = h1;
		done_n = 1'b0;

		case (mode_q) inside
			RUN_REVERSE: begin
				if (i7 <= st7) begin
					pos_n  = en_q;
					hist_n = h1 - 16'd1;
					done_n = (hist_n <= base);
				end else begin
					pos_n = pos_q - 6'd1;
				end
			end
			RUN_PINGPONG: begin
				if (!h1[0]) begin
					if (i7 + 7'd1 > en7) begin
						pos_n  = en_q;
						hist_n = h1 - 16'd1;
					end else begin
						pos_n = pos_q + 6'd1;
					end
				end else if (i7 <= st7) begin
					pos_n  = st_q;
					hist_n = h1 - 16'd1;
					done_n = (hist_n <= base);
				end else begin
					pos_n = pos_q - 6'd1;
				end
			end
			RUN_PENDULUM: begin
				if (!h1[0]) begin
					if (i7 + 7'd1 > en7) begin
						// turn at the top; a short range also turns at the bottom
						if (en7 <= st7 + 7'd1) begin
							pos_n  = st_q;
							hist_n = h1 - 16'd2;
							done_n = (hist_n <= base);
						end else begin
							pos_n  = en_q - 6'd1;
							hist_n = h1 - 16'd1;
						end
					end else begin
						pos_n = pos_q + 6'd1;
					end
				end else if (i7 <= st7 + 7'd1) begin
					pos_n  = st_q;
					hist_n = h1 - 16'd1;
					done_n = (hist_n <= base);
				end else begin
					pos_n = pos_q - 6'd1;
				end
			end
			RUN_BROWNIAN: begin
				// t7 is the moved position plus one
				if (t7 > en7 + 7'd1) begin
					pos_n = st_q;
				end else if (t7 <= st7) begin
					pos_n = en_q;
				end else begin
					pos_n = 6'(t7 - 7'd1);
				end
				hist_n = h1 - 16'd1;
				done_n = (hist_n <= base);
			end
			RUN_RANDOM, RUN_EXT_RANDOM: begin
				pos_n  = st_q + 6'(rem);
				hist_n = h1 - 16'd1;
				done_n = (hist_n <= base);
			end
			default: begin
				if (i7 + 7'd1 > en7) begin
					pos_n  = st_q;
					hist_n = h1 - 16'd1;
					done_n = (hist_n <= base);
				end else begin
					pos_n = pos_q + 6'd1;
				end
			end
		endcase
	end

	// state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hist_q <= '0;
			done_q <= 1'b0;
		end else if (cmd.commit) begin
			if (func_q == FUNC_INIT) begin
				pos_q  <= (mode_q == RUN_REVERSE) ? en_q : st_q;
				hist_q <= '0;
				done_q <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				hist_q <= hist_n;
				done_q <= done_n;
			end
		end
	end

	assign position  = pos_q;
	assign span_done = done_q;

endmodule

@@ src/run_mode_index_stepper_unit.sv @@
// Words are handled one at a time: a new word is accepted only once the
// result of the last one is committed, which waits on the bit-serial
// modulo of the 32-bit random word (one bit per cycle).
// A finished result waits in its register while the next word is taken.
// Reset (arst_n low, asynchronous): position and history clear to zero,
// no result pending.
module run_mode_index_stepper_unit
	import rmis_pkg::*;
#(
	parameter int INDEX_COUNT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  logic             func,
	input  logic [2:0]       run_mode,
	input  logic [5:0]       start_index,
	input  logic [5:0]       end_index,
	input  logic [6:0]       repeats,
	input  logic [RND_W-1:0] random_word,
	output logic             res_valid,
	input  logic             res_stall,
	output logic [5:0]       position,
	output logic             span_done
);

	rmis_cmd_t cmd;
	rmis_sts_t sts;

	rmis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rmis_dp #(
		.INDEX_COUNT (INDEX_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.run_mode    (run_mode),
		.start_index (start_index),
		.end_index   (end_index),
		.repeats     (repeats),
		.random_word (random_word),
		.position    (position),
		.span_done   (span_done)
	);

endmodule

@@ src/rmis_chk.sv @@
module rmis_chk
	import rmis_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_stall,
	input logic             func,
	input logic [2:0]       run_mode,
	input logic [5:0]       start_index,
	input logic [5:0]       end_index,
	input logic [6:0]       repeats,
	input logic [RND_W-1:0] random_word,
	input logic             res_valid,
	input logic             res_stall,
	input logic [5:0]       position,
	input logic             span_done
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && !cmd_stall;

	// a stalled input word holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(func) && $stable(run_mode)
			&& $stable(start_index) && $stable(end_index) && $stable(repeats)
			&& $stable(random_word))
		else $error("input word changed while stalled");

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(position) && $stable(span_done))
		else $error("result word changed while stalled");

	// one word at a time: busy right after accepting
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> cmd_stall)
		else $error("second word accepted while busy");

	// no result can appear in the cycle after a word is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !$rose(res_valid))
		else $error("result appeared too early");

	// a new result frees the input side at once
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !cmd_stall)
		else $error("input still stalled after result");

endmodule

bind run_mode_index_stepper_unit rmis_chk u_chk (.*);

@@ sim/tb_run_mode_index_stepper_unit.sv @@
`timescale 1ns / 1ps

module tb_run_mode_index_stepper_unit
	import rmis_pkg::*;
();

	localparam int POSITIONS = 64;
	// spare run mode code, steps like forward
	localparam logic [2:0] MODE_SPARE = 3'd7;
	// quiet cycles after the last result before the verdict
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic        func;
		logic [2:0]  run_mode;
		logic [5:0]  start_index;
		logic [5:0]  end_index;
		logic [6:0]  repeats;
		logic [31:0] random_word;
		int unsigned gap;
	} cmd_word_t;

	typedef struct {
		logic [5:0] position;
		logic       span_done;
	} step_result_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_LONG, STALL_RARE} stall_style_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	logic             func = 1'b0;
	logic [2:0]       run_mode = '0;
	logic [5:0]       start_index = '0;
	logic [5:0]       end_index = '0;
	logic [6:0]       repeats = '0;
	logic [RND_W-1:0] random_word = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [5:0]       position;
	logic             span_done;

	cmd_word_t    step_words[$];
	step_result_t due_results[$];
	cmd_word_t    cur_word;
	logic [5:0]   cursor_q = '0;
	logic [15:0]  history_q = '0;
	int unsigned  idle_left = 0;
	int           errors = 0;
	int           words_made = 0;
	int           burst_left = 0;
	stall_style_t stall_style = STALL_NONE;
	logic [7:0]   stall_cyc = '0;

	run_mode_index_stepper_unit #(.INDEX_COUNT(POSITIONS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.func        (func),
		.run_mode    (run_mode),
		.start_index (start_index),
		.end_index   (end_index),
		.repeats     (repeats),
		.random_word (random_word),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.position    (position),
		.span_done   (span_done)
	);

	always #5 clk = ~clk;

	// history word is stale unless it lies in (base, base + span]
	function automatic bit hist_stale(input int unsigned h, input int unsigned base);
		return (h < base + 1) || (h > base + HIST_SPAN);
	endfunction

	// step count for brownian and random modes, saturating
	function automatic int unsigned sat_count(input int unsigned span, input int unsigned reps);
		int unsigned c;
		c = span * reps;
		return (c > CNT_SAT) ? CNT_SAT : c;
	endfunction

	// next cursor position and span flag for one word
	function automatic step_result_t next_position(input cmd_word_t w, input logic [5:0] pos,
			input logic [15:0] hist, output logic [15:0] hist_next);
		int          st, en, idx;
		int unsigned h, span, reps;
		step_result_t r;
		st = int'(w.start_index);
		en = int'(w.end_index);
		if (st > POSITIONS - 1) st = POSITIONS - 1;
		if (en > POSITIONS - 1) en = POSITIONS - 1;
		if (en < st) en = st;
		span = 32'(en - st + 1);
		reps = 32'(w.repeats);
		idx = int'(pos);
		h = 32'(hist);
		r.span_done = 1'b0;
		if (w.func == FUNC_INIT) begin
			idx = (w.run_mode == RUN_REVERSE) ? en : st;
			h = 0;
		end else begin
			case (w.run_mode) inside
				RUN_REVERSE: begin
					if (hist_stale(h, BASE_REV)) h = BASE_REV + reps;
					idx--;
					if (idx < st) begin
						idx = en;
						h--;
						r.span_done = (h <= BASE_REV);
					end
				end
				RUN_PINGPONG: begin
					if (hist_stale(h, BASE_PPG)) h = BASE_PPG + reps * 2;
					if ((h & 1) == 0) begin
						idx++;
						if (idx > en) begin
							idx = en;
							h--;
						end
					end else begin
						idx--;
						if (idx < st) begin
							idx = st;
							h--;
							r.span_done = (h <= BASE_PPG);
						end
					end
				end
				RUN_PENDULUM: begin
					if (hist_stale(h, BASE_PEN)) h = BASE_PEN + reps * 2;
					if ((h & 1) == 0) begin
						idx++;
						if (idx > en) begin
							// turn at the top; a short range turns again at once
							idx = en - 1;
							h--;
							if (idx <= st) begin
								idx = st;
								h--;
								r.span_done = (h <= BASE_PEN);
							end
						end
					end else begin
						idx--;
						if (idx <= st) begin
							idx = st;
							h--;
							r.span_done = (h <= BASE_PEN);
						end
					end
				end
				RUN_BROWNIAN: begin
					if (hist_stale(h, BASE_BRN)) h = BASE_BRN + sat_count(span, reps);
					idx = idx + int'(w.random_word % 3) - 1;
					if (idx > en) idx = st;
					if (idx < st) idx = en;
					h--;
					r.span_done = (h <= BASE_BRN);
				end
				RUN_RANDOM, RUN_EXT_RANDOM: begin
					if (hist_stale(h, BASE_RND)) h = BASE_RND + sat_count(span, reps);
					idx = st + int'(w.random_word % span);
					h--;
					r.span_done = (h <= BASE_RND);
				end
				default: begin
					// forward, and the spare code
					if (hist_stale(h, BASE_FWD)) h = BASE_FWD + reps;
					idx++;
					if (idx > en) begin
						idx = st;
						h--;
						r.span_done = (h <= BASE_FWD);
					end
				end
			endcase
		end
		r.position = idx[5:0];
		hist_next = h[15:0];
		return r;
	endfunction

	// append one word; bursts of random length, the first word of each mostly followed by a gap
	task automatic queue_word(input logic f, input logic [2:0] m, input int st, input int en,
			input int reps, input logic [31:0] rnd);
		cmd_word_t w;
		w.func = f;
		w.run_mode = m;
		w.start_index = st[5:0];
		w.end_index = en[5:0];
		w.repeats = reps[6:0];
		w.random_word = rnd;
		w.gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			w.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		step_words.push_back(w);
		words_made++;
	endtask

	// mostly short ranges so spans complete often
	task automatic pick_range(output int st, output int en);
		case ($urandom_range(0, 9))
			0: begin
				st = $urandom_range(0, 63);
				en = $urandom_range(0, 63);
			end
			1: begin
				// end below start
				st = $urandom_range(1, 63);
				en = $urandom_range(0, st - 1);
			end
			default: begin
				st = $urandom_range(0, 63);
				en = st + $urandom_range(0, 5);
				if (en > 63) en = 63;
			end
		endcase
	endtask

	// stimulus
	initial begin : stimulus
		int st, en, reps, len;
		logic [2:0] m;

		// directed: wrap in forward, ping-pong and pendulum, zero and maximum repeats, extremes of fields
		queue_word(FUNC_INIT, RUN_FORWARD, 5, 7, 1, 32'h0);
		repeat (3) queue_word(FUNC_STEP, RUN_FORWARD, 5, 7, 1, 32'h0);
		queue_word(FUNC_INIT, RUN_REVERSE, 60, 63, 0, 32'hFFFF_FFFF);
		repeat (2) queue_word(FUNC_STEP, RUN_REVERSE, 60, 63, 0, 32'hFFFF_FFFF);
		queue_word(FUNC_INIT, RUN_PINGPONG, 3, 4, 1, 32'h0);
		repeat (4) queue_word(FUNC_STEP, RUN_PINGPONG, 3, 4, 1, 32'h0);
		queue_word(FUNC_INIT, RUN_PENDULUM, 10, 11, 2, 32'h0);
		repeat (3) queue_word(FUNC_STEP, RUN_PENDULUM, 10, 11, 2, 32'h0);
		// large count saturates
		queue_word(FUNC_STEP, RUN_BROWNIAN, 0, 63, 99, 32'hFFFF_FFFF);
		queue_word(FUNC_STEP, RUN_BROWNIAN, 0, 63, 127, 32'h0);
		// end below start collapses to one index
		queue_word(FUNC_STEP, RUN_RANDOM, 63, 0, 1, 32'hFFFF_FFFF);
		queue_word(FUNC_STEP, RUN_EXT_RANDOM, 0, 63, 127, 32'h1234_5678);
		queue_word(FUNC_STEP, MODE_SPARE, 0, 63, 3, 32'h0);
		// cursor outside the new range
		queue_word(FUNC_STEP, RUN_REVERSE, 20, 30, 1, 32'h0);

		// random: init then a run of steps in one mode, with some noise
		while (words_made < 1200) begin
			m = 3'($urandom_range(0, 7));
			pick_range(st, en);
			reps = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 127);
			if ($urandom_range(0, 6) != 0) begin
				queue_word(FUNC_INIT, m, st, en, reps, $urandom);
				len = $urandom_range(4, 40);
				repeat (len) queue_word(FUNC_STEP, m, st, en, reps, $urandom);
			end else begin
				repeat ($urandom_range(1, 6))
					queue_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
						$urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 127), $urandom);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// sample after the edge's updates have settled
		while (step_words.size() != 0 || cmd_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// driver: predict on acceptance, then present the next word after its gap
	always @(posedge clk or negedge arst_n) begin : drive
		step_result_t r;
		logic [15:0]  h_next;
		cmd_word_t    w;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			idle_left <= 0;
			cursor_q = '0;
			history_q = '0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				r = next_position(cur_word, cursor_q, history_q, h_next);
				cursor_q = r.position;
				history_q = h_next;
				due_results.push_back(r);
			end
			if (!cmd_valid || !cmd_stall) begin
				if (idle_left != 0) begin
					cmd_valid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (step_words.size() != 0) begin
					w = step_words.pop_front();
					cur_word <= w;
					func <= w.func;
					run_mode <= w.run_mode;
					start_index <= w.start_index;
					end_index <= w.end_index;
					repeats <= w.repeats;
					random_word <= w.random_word;
					cmd_valid <= 1'b1;
					idle_left <= w.gap;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result stall: style picked anew each time the 8-bit cycle counter wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_cyc <= '0;
			stall_style <= STALL_NONE;
		end else begin
			stall_cyc <= stall_cyc + 1'b1;
			if (stall_cyc == 8'd0) stall_style <= stall_style_t'($urandom_range(0, 3));
			case (stall_style)
				STALL_NONE: res_stall <= 1'b0;
				STALL_COIN: res_stall <= 1'($urandom_range(0, 1));
				STALL_LONG: res_stall <= stall_cyc[5];
				default:    res_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check
		step_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: position %0d span_done %0b",
					$time, position, span_done);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (position !== want.position) begin
					$display("%0t: position mismatch: expected %0d actual %0d",
						$time, want.position, position);
					errors++;
				end
				if (span_done !== want.span_done) begin
					$display("%0t: span_done mismatch: expected %0b actual %0b",
						$time, want.span_done, span_done);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
src/rmis_pkg.sv
src/rmis_mod.sv
src/rmis_ctrl.sv
src/rmis_dp.sv
src/run_mode_index_stepper_unit.sv
src/rmis_chk.sv
sim/tb_run_mode_index_stepper_unit.sv
